### rtl/overwriting_ring_line_framer_assert.svh
// assertion macros for the line framer
`ifndef OVERWRITING_RING_LINE_FRAMER_ASSERT_SVH
`define OVERWRITING_RING_LINE_FRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define ORLF_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("line framer check failed");
`define ORLF_ASSERT(lbl, prop) `ORLF_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define ORLF_ASSERT_CLK(lbl, clk, rst_n, prop)
`define ORLF_ASSERT(lbl, prop)
`endif

`endif

### rtl/orlf_pkg.sv
package orlf_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  localparam logic [7:0] NEWLINE     = 8'd10;
  localparam logic [7:0] CHUNK_RESET = 8'd255;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_end;
    logic       last;
  } result_t;

  // read data reaches the output buffer in the cycle after the read is issued
  typedef struct packed {
    logic push;
    logic chunk_end;
    logic last;
  } push_t;

  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } obuf_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  function automatic ptr_t ring_next(ptr_t p);
    ptr_t n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

endpackage

### rtl/orlf_rx_if.sv
interface orlf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/orlf_tx_if.sv
interface orlf_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       chunk_end;
  logic       last;

  modport source (output valid, output out_byte, output chunk_end, output last, input ready);
  modport sink (input valid, input out_byte, input chunk_end, input last, output ready);
endinterface

### rtl/orlf_ram.sv
module orlf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/orlf_ctrl.sv
module orlf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  output logic                in_ready_o,
  input  logic [7:0]          chunk_limit_i,
  input  orlf_pkg::obuf_stat_t obuf_stat_i,
  output logic                ram_we_o,
  output orlf_pkg::ptr_t      ram_waddr_o,
  output logic                ram_re_o,
  output orlf_pkg::ptr_t      ram_raddr_o,
  output orlf_pkg::push_t     push_o
);

  orlf_pkg::state_e state_q, state_d;
  orlf_pkg::ptr_t   wr_ptr_q, wr_ptr_d;
  orlf_pkg::ptr_t   rd_ptr_q, rd_ptr_d;
  orlf_pkg::cnt_t   fill_q, fill_d;
  orlf_pkg::cnt_t   left_q, left_d;
  logic [7:0]       in_chunk_q, in_chunk_d;
  orlf_pkg::push_t  push_q, push_d;

  logic       accept;
  logic       issue;
  logic [2:0] occupancy;
  logic [7:0] limit;
  logic [7:0] chunk_next;
  logic       is_final;
  logic       cend;
  orlf_pkg::cnt_t fill_inc;

  assign in_ready_o = (state_q == orlf_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // a slot freed by this cycle's pop counts as a credit
  assign occupancy = {1'b0, obuf_stat_i.count} + {2'b00, push_q.push};
  assign issue     = (state_q == orlf_pkg::ST_DRAIN) &&
                     ((occupancy < 3'd2) || obuf_stat_i.pop);

  assign limit      = (chunk_limit_i == 8'd0) ? 8'd1 : chunk_limit_i;
  assign chunk_next = in_chunk_q + 8'd1;
  assign is_final   = (left_q == orlf_pkg::CNT_W'(1));
  assign cend       = is_final || (chunk_next >= limit);
  assign fill_inc   = fill_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    fill_d     = fill_q;
    left_d     = left_q;
    in_chunk_d = in_chunk_q;
    push_d     = '0;

    if (accept) begin
      wr_ptr_d = orlf_pkg::ring_next(wr_ptr_q);
      if (fill_q < orlf_pkg::CNT_W'(orlf_pkg::DEPTH)) begin
        fill_d = fill_inc;
      end else begin
        // full: the oldest byte is overwritten
        rd_ptr_d = orlf_pkg::ring_next(rd_ptr_q);
      end
      if (in_byte_i == orlf_pkg::NEWLINE) begin
        left_d     = (fill_q < orlf_pkg::CNT_W'(orlf_pkg::DEPTH)) ? fill_inc : fill_q;
        fill_d     = '0;
        in_chunk_d = '0;
        state_d    = orlf_pkg::ST_DRAIN;
      end
    end

    if (issue) begin
      rd_ptr_d         = orlf_pkg::ring_next(rd_ptr_q);
      left_d           = left_q - 1'b1;
      in_chunk_d       = cend ? 8'd0 : chunk_next;
      push_d.push      = 1'b1;
      push_d.chunk_end = cend;
      push_d.last      = is_final;
      if (is_final) begin
        state_d = orlf_pkg::ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= orlf_pkg::ST_IDLE;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fill_q     <= '0;
      left_q     <= '0;
      in_chunk_q <= '0;
      push_q     <= '0;
    end else begin
      state_q    <= state_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      fill_q     <= fill_d;
      left_q     <= left_d;
      in_chunk_q <= in_chunk_d;
      push_q     <= push_d;
    end
  end

  assign ram_we_o    = accept;
  assign ram_waddr_o = wr_ptr_q;
  assign ram_re_o    = issue;
  assign ram_raddr_o = rd_ptr_q;
  assign push_o      = push_q;

endmodule

### rtl/orlf_obuf.sv
module orlf_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  orlf_pkg::push_t      push_i,
  input  logic [7:0]           data_i,
  output orlf_pkg::obuf_stat_t stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output orlf_pkg::result_t    out_o
);

  orlf_pkg::result_t ent_q [2];
  logic [1:0]        count_q, count_d;
  logic              wr_idx_q, rd_idx_q;
  logic              pop;

  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    count_d = count_q;
    if (push_i.push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i.push && pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      ent_q[wr_idx_q] <= '{out_byte: data_i, chunk_end: push_i.chunk_end,
                           last: push_i.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_idx_q <= 1'b0;
      rd_idx_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i.push) begin
        wr_idx_q <= ~wr_idx_q;
      end
      if (pop) begin
        rd_idx_q <= ~rd_idx_q;
      end
    end
  end

  assign out_o        = ent_q[rd_idx_q];
  assign stat_o.count = count_q;
  assign stat_o.pop   = pop;

endmodule

### rtl/overwriting_ring_line_framer.sv
// Newline framer over a ring of received bytes.
// rx carries one byte per transaction. Bytes go into a 64-entry ring; when the
// ring is full the oldest byte is overwritten. A newline (10) starts a drain of
// the whole pending line, oldest first, on tx: out_byte, chunk_end on every
// chunk_limit-th byte and on the newline, last on the newline.
// A newline holds rx.ready low while the line is read out of the ring, one byte
// per cycle through the single read port while tx does not stall.
// A two-entry output buffer sits before tx; when tx stalls, ring reads pause
// and resume without loss, and rx reopens once the last read has been issued.
// cfg_we_i writes chunk_limit (0 acts as 1); write it only while idle.
// Reset empties the ring, clears the pointers and sets chunk_limit to 255; no
// clearing pass is needed since only written entries are ever read.
`include "overwriting_ring_line_framer_assert.svh"

module overwriting_ring_line_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  orlf_rx_if.sink     rx,
  orlf_tx_if.source   tx,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0]           chunk_limit_q;
  logic                 ram_we;
  orlf_pkg::ptr_t       ram_waddr;
  logic                 ram_re;
  orlf_pkg::ptr_t       ram_raddr;
  logic [7:0]           ram_rdata;
  orlf_pkg::push_t      push;
  orlf_pkg::obuf_stat_t obuf_stat;
  orlf_pkg::result_t    result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_limit_q <= orlf_pkg::CHUNK_RESET;
    end else if (cfg_we_i) begin
      chunk_limit_q <= cfg_data_i;
    end
  end

  orlf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (rx.valid),
    .in_byte_i     (rx.rx_byte),
    .in_ready_o    (rx.ready),
    .chunk_limit_i (chunk_limit_q),
    .obuf_stat_i   (obuf_stat),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .push_o        (push)
  );

  orlf_ram #(
    .WIDTH (8),
    .DEPTH (orlf_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx.rx_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  orlf_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (ram_rdata),
    .stat_o      (obuf_stat),
    .out_valid_o (tx.valid),
    .out_ready_i (tx.ready),
    .out_o       (result)
  );

  assign tx.out_byte  = result.out_byte;
  assign tx.chunk_end = result.chunk_end;
  assign tx.last      = result.last;

  // output buffer never overflows
  `ORLF_ASSERT(a_obuf_no_overflow, !(obuf_stat.count == 2'd2 && push.push && !obuf_stat.pop))
  // every ring read lands in the output buffer next cycle
  `ORLF_ASSERT(a_read_then_push, ram_re |=> push.push)
  // no byte is taken while the ring is being read out
  `ORLF_ASSERT(a_no_accept_in_drain, ram_re |-> !rx.ready)
  // the newline result always closes its chunk
  `ORLF_ASSERT(a_last_ends_chunk, (tx.valid && tx.last) |-> tx.chunk_end)

endmodule
